// File: sv/go_back_n_sender_macros.svh
// ----------------------------------------------------------------------------
// Go-Back-N sender assertion macros
// Shorthand for clocked implication checks, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_MACROS_SVH
`define GO_BACK_N_SENDER_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define GBN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define GBN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/gbn_pkg.sv
// ----------------------------------------------------------------------------
// Go-Back-N sender package
// Default sizes, request codes and timer command codes.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int DEF_WINDOW_SIZE  = 4;
  localparam int DEF_SEQ_BITS     = 16;
  localparam int DEF_PAYLOAD_BITS = 32;

  typedef logic [1:0] req_t;
  typedef logic [1:0] tmr_t;

  // request codes
  localparam req_t REQ_SEND    = 2'd0;
  localparam req_t REQ_ACK     = 2'd1;
  localparam req_t REQ_TIMEOUT = 2'd2;

  // timer command codes
  localparam tmr_t TMR_NONE    = 2'd0;
  localparam tmr_t TMR_START   = 2'd1;
  localparam tmr_t TMR_STOP    = 2'd2;
  localparam tmr_t TMR_RESTART = 2'd3;

endpackage

// File: sv/go_back_n_sender.sv
// Steps: a stored send or a moving ack goes through the count, decide, add
//   and emit states; any other single-result item skips the add. A new beat
//   is taken only in idle, after the prior item's last result is emitted.
//   A timeout replays up to WINDOW_SIZE packets by the add, ring read, emit
//   loop. Reset (rst, synchronous): clears base, next sequence, window-full
//   flag and output valid; the ring is not cleared.
// ----------------------------------------------------------------------------
// Go-Back-N sender window
// Stores sent payloads in a ring of 2*WINDOW_SIZE entries, tracks the
// outstanding range, issues timer commands and replays on timeout.
// ----------------------------------------------------------------------------
module go_back_n_sender #(
  parameter int WINDOW_SIZE  = gbn_pkg::DEF_WINDOW_SIZE,
  parameter int SEQ_BITS     = gbn_pkg::DEF_SEQ_BITS,
  parameter int PAYLOAD_BITS = gbn_pkg::DEF_PAYLOAD_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  // input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              req_type,
  input  logic [PAYLOAD_BITS-1:0] send_payload,
  input  logic [SEQ_BITS-1:0]     ack_number,
  input  logic                    ack_valid,
  input  logic [SEQ_BITS-1:0]     expired_seq,
  // output channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    packet_out,
  output logic [SEQ_BITS-1:0]     packet_seq,
  output logic [PAYLOAD_BITS-1:0] packet_payload,
  output logic                    accepted,
  output logic [1:0]              timer_cmd,
  output logic [SEQ_BITS-1:0]     timer_seq,
  output logic                    window_full,
  output logic                    last
);

  localparam int RING_DEPTH = 2 * WINDOW_SIZE;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(WINDOW_SIZE + 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;  // wait for an input beat
  localparam logic [2:0] ST_COUNT  = 3'd1;  // count = next_seq - window_base
  localparam logic [2:0] ST_DECIDE = 3'd2;  // ack offset, branch on request
  localparam logic [2:0] ST_ADD    = 3'd3;  // advance next_seq / base, or replay address
  localparam logic [2:0] ST_READ   = 3'd4;  // ring data ready, build replay result
  localparam logic [2:0] ST_EMIT   = 3'd5;  // hand result to the output register

  logic [2:0] state;

  // window state
  logic [SEQ_BITS-1:0] window_base;
  logic [SEQ_BITS-1:0] next_seq;
  logic                waiting;

  // captured input beat
  gbn_pkg::req_t         req_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [SEQ_BITS-1:0]   ackn_q;
  logic                  ackv_q;
  logic [SEQ_BITS-1:0]   expd_q;

  // working registers
  logic [SEQ_BITS-1:0] cnt;      // outstanding count, unclamped
  logic [CNT_W-1:0]    rep_n;    // packets to replay
  logic [CNT_W-1:0]    rep_i;    // replay index
  logic [SEQ_BITS-1:0] rd_seq;   // sequence number of the ring read in flight

  // pending result
  logic                    r_pkt;
  logic [SEQ_BITS-1:0]     r_seq;
  logic [PAYLOAD_BITS-1:0] r_pay;
  logic                    r_acc;
  gbn_pkg::tmr_t           r_tcmd;
  logic [SEQ_BITS-1:0]     r_tseq;
  logic                    r_last;

  // shared adder
  logic [SEQ_BITS-1:0] alu_a;
  logic [SEQ_BITS-1:0] alu_b;
  logic                alu_sub;
  logic [SEQ_BITS-1:0] alu_sum;
  logic                alu_lt;

  // ring ports
  logic                    ring_we;
  logic [PAYLOAD_BITS-1:0] ring_rdata;

  logic slot_free;
  logic cnt_lt_w;
  logic send_ok;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign cnt_lt_w  = (cnt < SEQ_BITS'(WINDOW_SIZE));
  assign send_ok   = !waiting && cnt_lt_w;

  // Operand select for the shared adder: one modular add or subtract a step.
  always_comb begin
    alu_a   = next_seq;
    alu_b   = window_base;
    alu_sub = 1'b1;
    unique case (state)
      ST_DECIDE: begin
        alu_a   = ackn_q;
        alu_b   = window_base;
        alu_sub = 1'b1;
      end
      ST_ADD: begin
        alu_sub = 1'b0;
        if (req_q == gbn_pkg::REQ_SEND) begin
          alu_a = next_seq;
          alu_b = SEQ_BITS'(1);
        end else if (req_q == gbn_pkg::REQ_ACK) begin
          alu_a = ackn_q;
          alu_b = SEQ_BITS'(1);
        end else begin
          alu_a = window_base;
          alu_b = SEQ_BITS'(rep_i);
        end
      end
      default: begin
        alu_a   = next_seq;
        alu_b   = window_base;
        alu_sub = 1'b1;
      end
    endcase
  end

  gbn_alu #(
    .SEQ_BITS (SEQ_BITS)
  ) u_gbn_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .limit (cnt),
    .sum   (alu_sum),
    .lt    (alu_lt)
  );

  // Store the payload when an accepted send is decided.
  assign ring_we = (state == ST_DECIDE) && (req_q == gbn_pkg::REQ_SEND) && send_ok;

  gbn_ring #(
    .DEPTH (RING_DEPTH),
    .WIDTH (PAYLOAD_BITS)
  ) u_gbn_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (next_seq[IDX_W-1:0]),
    .wdata (pay_q),
    .raddr (alu_sum[IDX_W-1:0]),
    .rdata (ring_rdata)
  );

  // Sequencer and window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      window_base <= '0;
      next_seq    <= '0;
      waiting     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_COUNT;
          end
        end
        ST_COUNT: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          state <= ST_EMIT;
          unique case (req_q)
            gbn_pkg::REQ_SEND: begin
              if (send_ok) begin
                // window fills with this packet
                if (cnt == SEQ_BITS'(WINDOW_SIZE - 1)) begin
                  waiting <= 1'b1;
                end
                state <= ST_ADD;
              end else if (!waiting && cnt == SEQ_BITS'(WINDOW_SIZE)) begin
                waiting <= 1'b1;
              end
            end
            gbn_pkg::REQ_ACK: begin
              if (ackv_q && alu_lt) begin
                waiting <= 1'b0;
                state   <= ST_ADD;
              end
            end
            gbn_pkg::REQ_TIMEOUT: begin
              if (cnt != '0) begin
                state <= ST_ADD;
              end
            end
            default: begin
              state <= ST_EMIT;
            end
          endcase
        end
        ST_ADD: begin
          if (req_q == gbn_pkg::REQ_SEND) begin
            next_seq <= alu_sum;
            state    <= ST_EMIT;
          end else if (req_q == gbn_pkg::REQ_ACK) begin
            window_base <= alu_sum;
            state       <= ST_EMIT;
          end else begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            state <= r_last ? ST_IDLE : ST_ADD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: captured beat, counts and the pending result.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        req_q  <= req_type;
        pay_q  <= send_payload;
        ackn_q <= ack_number;
        ackv_q <= ack_valid;
        expd_q <= expired_seq;
      end
      ST_COUNT: begin
        cnt <= alu_sum;
      end
      ST_DECIDE: begin
        // default: result with nothing set but last
        r_pkt  <= 1'b0;
        r_seq  <= '0;
        r_pay  <= '0;
        r_acc  <= 1'b0;
        r_tcmd <= gbn_pkg::TMR_NONE;
        r_tseq <= '0;
        r_last <= 1'b1;
        rep_i  <= '0;
        rep_n  <= cnt_lt_w ? CNT_W'(cnt) : CNT_W'(WINDOW_SIZE);
        unique case (req_q)
          gbn_pkg::REQ_SEND: begin
            if (send_ok) begin
              r_pkt <= 1'b1;
              r_seq <= next_seq;
              r_pay <= pay_q;
              r_acc <= 1'b1;
              if (cnt == '0) begin
                r_tcmd <= gbn_pkg::TMR_START;
                r_tseq <= next_seq;
              end
            end else if (!waiting) begin
              r_acc <= 1'b1;
            end
          end
          gbn_pkg::REQ_TIMEOUT: begin
            if (cnt == '0) begin
              r_tcmd <= gbn_pkg::TMR_RESTART;
              r_tseq <= expd_q;
            end
          end
          default: begin
            r_acc <= 1'b0;
          end
        endcase
      end
      ST_ADD: begin
        rd_seq <= alu_sum;
        if (req_q == gbn_pkg::REQ_ACK) begin
          // base reaches next_seq: nothing left, stop the old timer
          if (alu_sum == next_seq) begin
            r_tcmd <= gbn_pkg::TMR_STOP;
            r_tseq <= window_base;
          end else begin
            r_tcmd <= gbn_pkg::TMR_RESTART;
            r_tseq <= alu_sum;
          end
        end
      end
      ST_READ: begin
        r_pkt  <= 1'b1;
        r_seq  <= rd_seq;
        r_pay  <= ring_rdata;
        r_acc  <= 1'b0;
        r_tcmd <= (rep_i == '0) ? gbn_pkg::TMR_RESTART : gbn_pkg::TMR_NONE;
        r_tseq <= (rep_i == '0) ? expd_q : '0;
        r_last <= (rep_i == rep_n - CNT_W'(1));
      end
      ST_EMIT: begin
        if (slot_free && !r_last) begin
          rep_i <= rep_i + CNT_W'(1);
        end
      end
      default: begin
        rep_i <= rep_i;
      end
    endcase
  end

  // Output register: load in EMIT once the previous beat has gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && slot_free) begin
      packet_out     <= r_pkt;
      packet_seq     <= r_seq;
      packet_payload <= r_pay;
      accepted       <= r_acc;
      timer_cmd      <= r_tcmd;
      timer_seq      <= r_tseq;
      window_full    <= waiting;
      last           <= r_last;
    end
  end

endmodule

// File: sv/gbn_alu.sv
// ----------------------------------------------------------------------------
// Go-Back-N shared sequence adder
// Modular add or subtract of sequence numbers with a less-than compare.
// ----------------------------------------------------------------------------
module gbn_alu #(
  parameter int SEQ_BITS = gbn_pkg::DEF_SEQ_BITS
) (
  input  logic [SEQ_BITS-1:0] a,
  input  logic [SEQ_BITS-1:0] b,
  input  logic                sub,
  input  logic [SEQ_BITS-1:0] limit,
  output logic [SEQ_BITS-1:0] sum,
  output logic                lt
);

  // two's complement subtract: invert b, carry in one
  assign sum = a + (b ^ {SEQ_BITS{sub}}) + SEQ_BITS'(sub);
  assign lt  = (sum < limit);

endmodule

// File: sv/gbn_ring.sv
// ----------------------------------------------------------------------------
// Go-Back-N payload ring
// One write port, one registered read port; contents undefined until written.
// ----------------------------------------------------------------------------
module gbn_ring #(
  parameter int DEPTH = 2 * gbn_pkg::DEF_WINDOW_SIZE,
  parameter int WIDTH = gbn_pkg::DEF_PAYLOAD_BITS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/gbn_checker.sv
// ----------------------------------------------------------------------------
// Go-Back-N sender port checker
// Watches the top-level ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "go_back_n_sender_macros.svh"

module gbn_checker #(
  parameter int SEQ_BITS     = gbn_pkg::DEF_SEQ_BITS,
  parameter int PAYLOAD_BITS = gbn_pkg::DEF_PAYLOAD_BITS
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [1:0]              req_type,
  input logic [PAYLOAD_BITS-1:0] send_payload,
  input logic [SEQ_BITS-1:0]     ack_number,
  input logic                    ack_valid,
  input logic [SEQ_BITS-1:0]     expired_seq,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    packet_out,
  input logic [SEQ_BITS-1:0]     packet_seq,
  input logic [PAYLOAD_BITS-1:0] packet_payload,
  input logic                    accepted,
  input logic [1:0]              timer_cmd,
  input logic [SEQ_BITS-1:0]     timer_seq,
  input logic                    window_full,
  input logic                    last
);

  logic                               in_stall;
  logic                               out_stall;
  logic [2*SEQ_BITS+PAYLOAD_BITS+2:0] in_beat;
  logic [2*SEQ_BITS+PAYLOAD_BITS+5:0] out_beat;
  logic                               no_pkt;
  logic                               pkt_zero;
  logic                               send_beat;
  logic                               tmr_ok;

  assign in_stall  = in_valid && !in_ready;
  assign out_stall = out_valid && !out_ready;
  assign in_beat   = {req_type, send_payload, ack_number, ack_valid, expired_seq};
  assign out_beat  = {packet_out, packet_seq, packet_payload, accepted, timer_cmd,
                      timer_seq, window_full, last};
  assign no_pkt    = out_valid && !packet_out;
  assign pkt_zero  = (packet_seq == '0) && (packet_payload == '0);
  assign send_beat = out_valid && accepted;
  assign tmr_ok    = (timer_cmd != gbn_pkg::TMR_STOP) && (timer_cmd != gbn_pkg::TMR_RESTART);

  // hold a waiting input beat
  `GBN_ASSERT_NEXT(a_in_hold, in_stall, in_valid && $stable(in_beat), "waiting input changed")

  // hold a stalled result beat
  `GBN_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_beat), "stalled beat changed")

  // no packet: sequence and payload read zero
  `GBN_ASSERT_NOW(a_no_pkt_zero, no_pkt, pkt_zero, "empty result carries packet fields")

  // an accepted send never stops or restarts the timer
  `GBN_ASSERT_NOW(a_send_no_stop, send_beat, tmr_ok, "send result stops timer")

  // no new input while a replay is still in progress
  `GBN_ASSERT_NOW(a_replay_busy, out_valid && !last, !in_ready, "input taken during replay")

endmodule

bind go_back_n_sender gbn_checker #(
  .SEQ_BITS     (SEQ_BITS),
  .PAYLOAD_BITS (PAYLOAD_BITS)
) u_gbn_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .req_type       (req_type),
  .send_payload   (send_payload),
  .ack_number     (ack_number),
  .ack_valid      (ack_valid),
  .expired_seq    (expired_seq),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .packet_out     (packet_out),
  .packet_seq     (packet_seq),
  .packet_payload (packet_payload),
  .accepted       (accepted),
  .timer_cmd      (timer_cmd),
  .timer_seq      (timer_seq),
  .window_full    (window_full),
  .last           (last)
);
